FILE: rtl/mse_pkg.sv
// Package for the MIPS subset execute block: opcodes, default sizes and
// the payload types of the input and result channels. No dependencies.
`default_nettype none

package mse_pkg;

    // Default store sizes
    localparam int DEF_NUM_REGS   = 30;
    localparam int DEF_MEM_BYTES  = 4096;
    localparam int DEF_PROG_DEPTH = 1024;

    // Opcodes of the decoded instruction
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADDI = 5'd1,
        OP_AND  = 5'd2,
        OP_ANDI = 5'd3,
        OP_BEQ  = 5'd4,
        OP_BNE  = 5'd5,
        OP_J    = 5'd6,
        OP_JAL  = 5'd7,
        OP_JR   = 5'd8,
        OP_LW   = 5'd9,
        OP_NOP  = 5'd10,
        OP_NOR  = 5'd11,
        OP_ORI  = 5'd12,
        OP_SLT  = 5'd13,
        OP_SLTI = 5'd14,
        OP_SLL  = 5'd15,
        OP_SRA  = 5'd16,
        OP_SUB  = 5'd17,
        OP_SW   = 5'd18
    } t_op;

    // One decoded instruction
    typedef struct packed {
        logic [4:0]         operation;
        logic [4:0]         src_reg;
        logic [4:0]         second_reg;
        logic [4:0]         dest_reg;
        logic signed [15:0] immediate;
        logic [9:0]         target_index;
        logic [9:0]         current_index;
    } t_in_item;

    // One result
    typedef struct packed {
        logic               redirect;
        logic [9:0]         next_index;
        logic               write_valid;
        logic [4:0]         write_reg;
        logic signed [31:0] write_value;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/mse_if.sv
// Valid/ready channels for instruction beats and result beats.
// Depends on mse_pkg for the payload types.
`default_nettype none

interface mse_in_if;
    logic              valid;
    logic              ready;
    mse_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mse_out_if;
    logic               valid;
    logic               ready;
    mse_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mips_subset_execute.sv
// Each result passes the instruction-field, exec, first-product, second-product and
// memory stages and the result register. Throughput: one beat per cycle for independent
// items while the result is taken; lw and sw hold the memory stage while it moves the
// word byte by byte. An item reading a register that an earlier item still has to
// write waits until that item leaves the memory stage. Reset: synchronous, active low;
// register-file valid bits clear at once, then a pass zeroes every data memory byte.
`default_nettype none

// Top level: register-file RAMs, exec stage, two mod-by-constant pipelines
// (byte address, next index), a byte-serial memory stage and the result register.
// Depends on mse_pkg, mse_if (mse_in_if, mse_out_if) and mse_ram.
module mips_subset_execute #(
    parameter int NUM_REGS   = mse_pkg::DEF_NUM_REGS,
    parameter int MEM_BYTES  = mse_pkg::DEF_MEM_BYTES,
    parameter int PROG_DEPTH = mse_pkg::DEF_PROG_DEPTH
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    mse_in_if.sink    i_in,
    mse_out_if.source o_out
);

    localparam int RW   = $clog2(NUM_REGS);
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int AWP1 = AW + 1;
    localparam int NSTG = 5;

    localparam logic [5:0]    NREG     = 6'(NUM_REGS);
    localparam logic [4:0]    JAL_REG  = 5'(NUM_REGS - 1);
    localparam logic [31:0]   A_MOD    = 32'(MEM_BYTES);
    localparam logic [31:0]   A_RECIP  = 32'((64'd1 << 32) / 64'(MEM_BYTES));
    localparam logic [31:0]   P_MOD    = 32'(PROG_DEPTH);
    localparam logic [31:0]   P_RECIP  = 32'((64'd1 << 32) / 64'(PROG_DEPTH));
    localparam logic [AW:0]   A_LIM    = AWP1'(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    localparam logic [2:0]    MC_DONE  = 3'd4;

    // Per-stage control, shifted on every advance
    typedef struct packed {
        logic       vld;
        logic       wr;
        logic [4:0] widx;
        logic       ld;
        logic       st;
    } t_ctl;

    t_ctl r_ctl [NSTG];
    t_ctl n_ctl;
    t_ctl c5;

    logic [NUM_REGS-1:0] r_rf_vld;
    logic                r_clr;
    logic [AW-1:0]       r_clr_addr;
    logic [2:0]          r_mcnt;
    logic                r_out_v;
    mse_pkg::t_out_item  r_out;
    mse_pkg::t_out_item  n_out;

    // Stage 1: instruction fields
    logic [4:0]  r_p1_op;
    logic [15:0] r_p1_imm;
    logic [9:0]  r_p1_tgt;
    logic [9:0]  r_p1_cur;
    logic        r_p1_aok;
    logic        r_p1_bok;
    // Stage 2: exec results
    logic [31:0] r_p2_wval, r_p2_ax, r_p2_nx, r_p2_sd;
    logic        r_p2_redir;
    // Stage 3: first products
    logic [31:0] r_p3_wval, r_p3_ax, r_p3_aq, r_p3_nx, r_p3_nq, r_p3_sd;
    logic        r_p3_redir;
    // Stage 4: second products
    logic [31:0] r_p4_wval, r_p4_ax, r_p4_aqc, r_p4_nx, r_p4_nqc, r_p4_sd;
    logic        r_p4_redir;
    // Stage 5: memory stage
    logic [31:0] r_p5_wval, r_p5_sd;
    logic [AW-1:0] r_p5_base;
    logic [9:0]  r_p5_next;
    logic        r_p5_redir;
    logic [7:0]  r_lb [3];

    logic        adv, hazard, in_rdy, in_acc;
    logic        use_a, use_b, has_dest;
    logic [4:0]  d_idx;
    logic        a_ok, b_ok;
    logic [31:0] rfa_q, rfb_q, op_a, op_b, imm32;
    logic [31:0] ex_wval, ex_nx;
    logic        ex_redir;
    logic [63:0] a_prod, n_prod;
    logic [31:0] a_qc, n_qc, a_r, a_rc, n_r, n_rc;
    logic [AW:0] a_sum, a_fix;
    logic [AW-1:0] dm_addr;
    logic [31:0] st_shift;
    logic [7:0]  dm_q;
    logic        is_mem, mem_issue, mem_rdy;
    logic [31:0] ld_word, fin_wval;
    logic        rf_we, dm_we;
    logic [AW-1:0] dm_waddr;
    logic [7:0]  dm_wdata;

    assign c5 = r_ctl[NSTG-1];

    // Decode of the incoming beat: register use and destination
    always_comb begin
        has_dest = 1'b0;
        d_idx    = '0;
        use_a    = 1'b0;
        use_b    = 1'b0;
        n_ctl    = '0;
        unique case (i_in.data.operation) inside
            mse_pkg::OP_ADD, mse_pkg::OP_AND, mse_pkg::OP_NOR, mse_pkg::OP_SLT,
            mse_pkg::OP_SUB: begin
                has_dest = 1'b1;
                d_idx    = i_in.data.dest_reg;
                use_a    = 1'b1;
                use_b    = 1'b1;
            end
            mse_pkg::OP_ADDI, mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_SLTI,
            mse_pkg::OP_SLL, mse_pkg::OP_SRA: begin
                has_dest = 1'b1;
                d_idx    = i_in.data.second_reg;
                use_a    = 1'b1;
            end
            mse_pkg::OP_LW: begin
                has_dest = 1'b1;
                d_idx    = i_in.data.second_reg;
                use_a    = 1'b1;
                n_ctl.ld = 1'b1;
            end
            mse_pkg::OP_SW: begin
                use_a    = 1'b1;
                use_b    = 1'b1;
                n_ctl.st = 1'b1;
            end
            mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
                use_a = 1'b1;
                use_b = 1'b1;
            end
            mse_pkg::OP_JR: begin
                use_a = 1'b1;
            end
            mse_pkg::OP_JAL: begin
                has_dest = 1'b1;
                d_idx    = JAL_REG;
            end
            default: ;
        endcase
        n_ctl.vld  = 1'b1;
        n_ctl.wr   = has_dest && ({1'b0, d_idx} < NREG);
        n_ctl.widx = n_ctl.wr ? d_idx : 5'd0;
    end

    // Interlock: a source register still pending a write in any stage
    always_comb begin
        hazard = 1'b0;
        for (int s = 0; s < NSTG; s++) begin
            if (r_ctl[s].vld && r_ctl[s].wr &&
                ((use_a && r_ctl[s].widx == i_in.data.src_reg) ||
                 (use_b && r_ctl[s].widx == i_in.data.second_reg))) begin
                hazard = 1'b1;
            end
        end
    end

    // Written-before flags; unwritten or out-of-range registers read as zero
    assign a_ok = ({1'b0, i_in.data.src_reg} < NREG) &&
                  r_rf_vld[i_in.data.src_reg[RW-1:0]];
    assign b_ok = ({1'b0, i_in.data.second_reg} < NREG) &&
                  r_rf_vld[i_in.data.second_reg[RW-1:0]];

    // Pipeline advance and input handshake
    assign is_mem    = c5.vld && (c5.ld || c5.st);
    assign mem_issue = is_mem && (r_mcnt != MC_DONE);
    assign mem_rdy   = !is_mem || (r_mcnt == MC_DONE);
    assign adv       = mem_rdy && (!r_out_v || o_out.ready);
    assign in_rdy    = i_rst_n && !r_clr && adv && !hazard;
    assign in_acc    = i_in.valid && in_rdy;
    assign i_in.ready = in_rdy;

    // Register file: two copies for two read ports, written alike
    assign rf_we = adv && c5.vld && c5.wr;

    mse_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (c5.widx[RW-1:0]),
        .i_wdata (fin_wval),
        .i_re    (in_acc),
        .i_raddr (i_in.data.src_reg[RW-1:0]),
        .o_rdata (rfa_q)
    );

    mse_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (c5.widx[RW-1:0]),
        .i_wdata (fin_wval),
        .i_re    (in_acc),
        .i_raddr (i_in.data.second_reg[RW-1:0]),
        .o_rdata (rfb_q)
    );

    // Exec stage: ALU, branch decision, address sum
    assign op_a  = r_p1_aok ? rfa_q : 32'd0;
    assign op_b  = r_p1_bok ? rfb_q : 32'd0;
    assign imm32 = {{16{r_p1_imm[15]}}, r_p1_imm};

    always_comb begin
        ex_wval  = '0;
        ex_redir = 1'b0;
        ex_nx    = {22'd0, r_p1_cur} + 32'd1;
        unique case (r_p1_op) inside
            mse_pkg::OP_ADD:  ex_wval = op_a + op_b;
            mse_pkg::OP_ADDI: ex_wval = op_a + imm32;
            mse_pkg::OP_AND:  ex_wval = op_a & op_b;
            mse_pkg::OP_ANDI: ex_wval = op_a & imm32;
            mse_pkg::OP_NOR:  ex_wval = ~(op_a | op_b);
            mse_pkg::OP_ORI:  ex_wval = op_a | imm32;
            mse_pkg::OP_SLT:  ex_wval = {31'd0, $signed(op_a) < $signed(op_b)};
            mse_pkg::OP_SLTI: ex_wval = {31'd0, $signed(op_a) < $signed(imm32)};
            mse_pkg::OP_SLL:  ex_wval = op_a << r_p1_imm[4:0];
            mse_pkg::OP_SRA:  ex_wval = 32'($signed(op_a) >>> r_p1_imm[4:0]);
            mse_pkg::OP_SUB:  ex_wval = op_a - op_b;
            mse_pkg::OP_BEQ: begin
                if (op_a == op_b) begin
                    ex_redir = 1'b1;
                    ex_nx    = {22'd0, r_p1_tgt};
                end
            end
            mse_pkg::OP_BNE: begin
                if (op_a != op_b) begin
                    ex_redir = 1'b1;
                    ex_nx    = {22'd0, r_p1_tgt};
                end
            end
            mse_pkg::OP_J: begin
                ex_redir = 1'b1;
                ex_nx    = {22'd0, r_p1_tgt};
            end
            mse_pkg::OP_JAL: begin
                ex_redir = 1'b1;
                ex_nx    = {22'd0, r_p1_tgt};
                ex_wval  = {22'd0, r_p1_cur};
            end
            mse_pkg::OP_JR: begin
                ex_redir = 1'b1;
                ex_nx    = op_a + 32'd1;
            end
            default: ;
        endcase
    end

    // Mod by constant: q ~ x * floor(2^32 / m) >> 32, never more than one low
    assign a_prod = r_p2_ax * A_RECIP;
    assign n_prod = r_p2_nx * P_RECIP;
    assign a_qc   = r_p3_aq * A_MOD;
    assign n_qc   = r_p3_nq * P_MOD;
    // remainder stays below twice the modulus: one compare-subtract
    assign a_r    = r_p4_ax - r_p4_aqc;
    assign a_rc   = (a_r >= A_MOD) ? a_r - A_MOD : a_r;
    assign n_r    = r_p4_nx - r_p4_nqc;
    assign n_rc   = (n_r >= P_MOD) ? n_r - P_MOD : n_r;

    // Memory stage: one byte per cycle, address wraps at the memory size
    assign a_sum    = {1'b0, r_p5_base} + AWP1'(r_mcnt[1:0]);
    assign a_fix    = (a_sum >= A_LIM) ? a_sum - A_LIM : a_sum;
    assign dm_addr  = a_fix[AW-1:0];
    assign st_shift = r_p5_sd >> {r_mcnt[1:0], 3'b000};
    assign ld_word  = {dm_q, r_lb[2], r_lb[1], r_lb[0]};
    assign fin_wval = c5.ld ? ld_word : r_p5_wval;

    // Write port shared with the clearing pass after reset
    assign dm_we    = r_clr || (mem_issue && c5.st);
    assign dm_waddr = r_clr ? r_clr_addr : dm_addr;
    assign dm_wdata = r_clr ? 8'd0 : st_shift[7:0];

    mse_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (mem_issue && c5.ld),
        .i_raddr (dm_addr),
        .o_rdata (dm_q)
    );

    // Result beat
    always_comb begin
        n_out.redirect    = r_p5_redir;
        n_out.next_index  = r_p5_next;
        n_out.write_valid = c5.wr;
        n_out.write_reg   = c5.widx;
        n_out.write_value = c5.wr ? fin_wval : 32'd0;
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_ctl[s] <= '0;
            end
            r_rf_vld   <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_mcnt     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            // data memory clearing pass
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clr <= 1'b0;
                end
            end
            // stage shift
            if (adv) begin
                r_ctl[0] <= in_acc ? n_ctl : '0;
                for (int s = 1; s < NSTG; s++) begin
                    r_ctl[s] <= r_ctl[s-1];
                end
            end
            // byte counter of the memory stage
            if (adv) begin
                r_mcnt <= '0;
            end else if (mem_issue) begin
                r_mcnt <= r_mcnt + 3'd1;
            end
            // register written-before flags
            if (rf_we) begin
                r_rf_vld[c5.widx[RW-1:0]] <= 1'b1;
            end
            // output register
            if (adv) begin
                r_out_v <= c5.vld;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_op  <= i_in.data.operation;
            r_p1_imm <= i_in.data.immediate;
            r_p1_tgt <= i_in.data.target_index;
            r_p1_cur <= i_in.data.current_index;
            r_p1_aok <= a_ok;
            r_p1_bok <= b_ok;
        end
        if (adv) begin
            r_p2_wval  <= ex_wval;
            r_p2_redir <= ex_redir;
            r_p2_ax    <= op_a + imm32;
            r_p2_nx    <= ex_nx;
            r_p2_sd    <= op_b;

            r_p3_wval  <= r_p2_wval;
            r_p3_redir <= r_p2_redir;
            r_p3_ax    <= r_p2_ax;
            r_p3_aq    <= a_prod[63:32];
            r_p3_nx    <= r_p2_nx;
            r_p3_nq    <= n_prod[63:32];
            r_p3_sd    <= r_p2_sd;

            r_p4_wval  <= r_p3_wval;
            r_p4_redir <= r_p3_redir;
            r_p4_ax    <= r_p3_ax;
            r_p4_aqc   <= a_qc;
            r_p4_nx    <= r_p3_nx;
            r_p4_nqc   <= n_qc;
            r_p4_sd    <= r_p3_sd;

            r_p5_wval  <= r_p4_wval;
            r_p5_redir <= r_p4_redir;
            r_p5_base  <= a_rc[AW-1:0];
            r_p5_next  <= n_rc[9:0];
            r_p5_sd    <= r_p4_sd;

            r_out      <= n_out;
        end
        // load bytes 0..2 land in the cycle after their read
        if (c5.vld && c5.ld && r_mcnt != 3'd0 && r_mcnt != MC_DONE) begin
            r_lb[2'(r_mcnt[1:0] - 2'd1)] <= dm_q;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/mse_checker.sv
// Port-level checks of mips_subset_execute, attached by the bind below.
// Depends on mse_pkg for the result payload type and the default register count.
`default_nettype none

module mse_checker #(
    parameter int NUM_REGS = mse_pkg::DEF_NUM_REGS
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire mse_pkg::t_out_item i_out_data
);

    localparam logic [5:0] NREG = 6'(NUM_REGS);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // No register write reported: index and value are zero
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.write_valid |->
            i_out_data.write_reg == 5'd0 && i_out_data.write_value == 32'sd0)
        else $error("write fields not cleared without a write");

    // Reported writes target an existing register
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.write_valid |-> {1'b0, i_out_data.write_reg} < NREG)
        else $error("write to a register beyond the file");

    // After reset no result is pending and the memory clear holds off input
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("activity right after reset");

endmodule

bind mips_subset_execute mse_checker #(.NUM_REGS(NUM_REGS)) u_mse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
